// ----- hw/rtl/scrolling_text_console_dirty_map_unit_assert.svh -----
// assertion macros for the scrolling text console dirty map unit
`ifndef SCROLLING_TEXT_CONSOLE_DIRTY_MAP_UNIT_ASSERT_SVH
`define SCROLLING_TEXT_CONSOLE_DIRTY_MAP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define STCDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define STCDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/stcdm_pkg.sv -----
// shared types and constants of the scrolling text console dirty map unit
`default_nettype none

package stcdm_pkg;

  // input commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FETCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_COLS   = 3'd0;
  localparam logic [2:0] REG_ROWS   = 3'd1;
  localparam logic [2:0] REG_CHAR_W = 3'd2;
  localparam logic [2:0] REG_LINE_H = 3'd3;
  localparam logic [2:0] REG_ORG_X  = 3'd4;
  localparam logic [2:0] REG_ORG_Y  = 3'd5;

  // character codes
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] LINE_FEED  = 8'h0A;

  // dirty map word layout
  localparam int DWORD_BITS = 32;

  // sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_PUT    = 8'b0000_0100,
    ST_PUTW   = 8'b0000_1000,
    ST_SCROLL = 8'b0001_0000,
    ST_FSCAN  = 8'b0010_0000,
    ST_FDIV   = 8'b0100_0000,
    ST_FOUT   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scrolling_text_console_dirty_map_unit.sv -----
// scrolling text console with a per-cell dirty map held in two memories
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid in_ready in_cmd in_ch            | to block
//   out      | out_valid out_ready out_found out_pix_x   | from block
//            | out_pix_y out_glyph_code out_more         |
//   cfg      | cfg_valid cfg_ready cfg_index cfg_data    | to block
//
// printable item: cell read in ST_PUT, written back in ST_PUTW; line feed or row wrap adds a scroll,
//   one cell per cycle through the cell store read-modify-write path.
// fetch item: a dirty word scan that stops early at a second dirty cell, then
//   restoring division over the address bits when a cell was found, then the output load.
// clear item and reset: a sweep over all MAX_COLS*MAX_ROWS cells of both memories,
//   no item taken meanwhile; cfg writes are taken in every cycle.
// a waiting result holds only a following fetch, not writes or scrolls.
`default_nettype none

`include "scrolling_text_console_dirty_map_unit_assert.svh"

module scrolling_text_console_dirty_map_unit
  import stcdm_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [15:0]      out_pix_x,
  output logic [15:0]      out_pix_y,
  output logic [7:0]       out_glyph_code,
  output logic             out_more,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NW    = (CELLS + DWORD_BITS - 1) / DWORD_BITS;
  localparam int WIW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DCW   = $clog2(IW + 1);

  // dirty word index of a cell address
  function automatic logic [WIW-1:0] word_of(input logic [IW-1:0] a);
    logic [IW+4:0] e;
    e = {5'b0, a};
    return e[WIW+4:5];
  endfunction

  // bit position of a cell address inside its dirty word
  function automatic logic [4:0] bit_of(input logic [IW-1:0] a);
    logic [IW+4:0] e;
    e = {5'b0, a};
    return e[4:0];
  endfunction

  // lowest set bit of a dirty word
  function automatic logic [4:0] lowest_bit(input logic [31:0] w);
    logic [4:0] idx;
    idx = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (w[j]) idx = 5'(j);
    end
    return idx;
  endfunction

  // state and registers
  state_t          state_r, state_nxt;
  logic [6:0]      cols_in_use_r, cols_in_use_nxt;
  logic [5:0]      rows_in_use_r, rows_in_use_nxt;
  logic [7:0]      char_width_r, char_width_nxt;
  logic [7:0]      line_height_r, line_height_nxt;
  logic [15:0]     origin_x_r, origin_x_nxt;
  logic [15:0]     origin_y_r, origin_y_nxt;
  logic [6:0]      cursor_r, cursor_nxt;
  logic [IW-1:0]   sweep_r, sweep_nxt;
  logic [IW-1:0]   lim_m1_r, lim_m1_nxt;
  logic [CW-1:0]   put_col_r, put_col_nxt;
  logic            put_wrap_r, put_wrap_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic [IW-1:0]   d_r, d_nxt;
  logic            wb_vld_r, wb_vld_nxt;
  logic [IW-1:0]   wb_addr_r, wb_addr_nxt;
  logic            wb_use_src_r, wb_use_src_nxt;
  logic [7:0]      wb_const_r, wb_const_nxt;
  logic            prev_vld_r, prev_vld_nxt;
  logic [WIW-1:0]  prev_idx_r, prev_idx_nxt;
  logic [31:0]     prev_word_r, prev_word_nxt;
  logic [WIW-1:0]  scan_w_r, scan_w_nxt;
  logic            scan_iss_r, scan_iss_nxt;
  logic            scan_v_r, scan_v_nxt;
  logic [WIW-1:0]  eval_w_r, eval_w_nxt;
  logic            first_found_r, first_found_nxt;
  logic [IW-1:0]   first_idx_r, first_idx_nxt;
  logic [31:0]     first_word_r, first_word_nxt;
  logic            more_r, more_nxt;
  logic [IW-1:0]   quo_r, quo_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [DCW-1:0]  div_cnt_r, div_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_found_r, out_found_nxt;
  logic [15:0]     out_pix_x_r, out_pix_x_nxt;
  logic [15:0]     out_pix_y_r, out_pix_y_nxt;
  logic [7:0]      out_glyph_r, out_glyph_nxt;
  logic            out_more_r, out_more_nxt;

  // memories and their registered read data
  logic [7:0]      cell_mem [CELLS];
  logic [31:0]     dirty_mem [NW];
  logic [7:0]      cell_rda_r, cell_rdb_r;
  logic [31:0]     dirty_rd_r;

  // memory port controls
  logic [IW-1:0]   rd_src_addr, rd_dst_addr;
  logic [WIW-1:0]  dirty_raddr;
  logic            cell_we, dirty_we;
  logic [IW-1:0]   cell_waddr;
  logic [7:0]      cell_wdata;
  logic [WIW-1:0]  dirty_waddr;
  logic [31:0]     dirty_wdata;

  // effective geometry with saturation
  logic [CW-1:0]   cols_eff;
  logic [RW-1:0]   rows_eff;
  logic [CW+RW-1:0] lim_full, lim_dec;
  logic [IW-1:0]   lim_m1_c;

  always_comb begin
    if (cols_in_use_r == 7'd0) begin
      cols_eff = CW'(1);
    end else if (32'(cols_in_use_r) > 32'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cols_in_use_r);
    end
    if (rows_in_use_r == 6'd0) begin
      rows_eff = RW'(1);
    end else if (32'(rows_in_use_r) > 32'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_in_use_r);
    end
  end

  assign lim_full = cols_eff * rows_eff;
  assign lim_dec  = lim_full - 1'b1;
  assign lim_m1_c = lim_dec[IW-1:0];

  // cursor column for a printable item
  logic [CW+6:0]   cur_ext;
  logic [CW-1:0]   col_sel;
  logic [CW:0]     col_inc;
  logic            col_wrap;

  assign cur_ext  = {{CW{1'b0}}, cursor_r};
  assign col_sel  = (cursor_r < cols_eff) ? cur_ext[CW-1:0] : cols_eff - 1'b1;
  assign col_inc  = {1'b0, col_sel} + 1'b1;
  assign col_wrap = col_inc >= {1'b0, cols_eff};

  // put and scroll addresses
  logic [IW+CW-1:0] put_ext, src_full;
  logic [CW+6:0]    cur_inc;
  logic [IW-1:0]    put_addr;
  logic             d_ge_cols;

  assign put_ext   = {{IW{1'b0}}, put_col_r};
  assign put_addr  = put_ext[IW-1:0];
  assign cur_inc   = {7'b0, put_col_r} + 1'b1;
  assign src_full  = {{CW{1'b0}}, d_r} - {{IW{1'b0}}, cols_eff};
  assign d_ge_cols = d_r >= cols_eff;

  // write-back stage with dirty word forwarding
  logic [WIW-1:0]  wb_word_idx;
  logic [4:0]      wb_bit;
  logic [31:0]     wb_base, wb_word;
  logic [7:0]      wb_val;
  logic            wb_differ;

  assign wb_word_idx = word_of(wb_addr_r);
  assign wb_bit      = bit_of(wb_addr_r);
  assign wb_base     = (prev_vld_r && (prev_idx_r == wb_word_idx)) ? prev_word_r
                                                                   : dirty_rd_r;
  assign wb_val      = wb_use_src_r ? cell_rda_r : wb_const_r;
  assign wb_differ   = wb_val != cell_rdb_r;
  assign wb_word     = wb_base | ({31'b0, wb_differ} << wb_bit);

  // dirty scan evaluation
  logic [WIW-1:0]  last_w;
  logic [4:0]      last_bit;
  logic [31:0]     last_mask, scan_mask, masked;
  logic            masked_any, masked_multi;
  logic [4:0]      hit_bit;
  logic [WIW+4:0]  hit_cat;
  logic [IW-1:0]   hit_idx;

  assign last_w   = word_of(lim_m1_r);
  assign last_bit = bit_of(lim_m1_r);

  always_comb begin
    for (int j = 0; j < 32; j++) begin
      last_mask[j] = 5'(j) <= last_bit;
    end
  end

  assign scan_mask    = (eval_w_r == last_w) ? last_mask : '1;
  assign masked       = dirty_rd_r & scan_mask;
  assign masked_any   = masked != 32'd0;
  assign masked_multi = (masked & (masked - 32'd1)) != 32'd0;
  assign hit_bit      = lowest_bit(masked);
  assign hit_cat      = {eval_w_r, hit_bit};
  assign hit_idx      = hit_cat[IW-1:0];

  // restoring divide step: address into row and column
  logic [CW:0]     div_tmp, div_diff;
  logic            div_ok;
  logic [IW:0]     quo_sh;

  assign div_tmp  = {rem_r, quo_r[IW-1]};
  assign div_ok   = div_tmp >= {1'b0, cols_eff};
  assign div_diff = div_tmp - {1'b0, cols_eff};
  assign quo_sh   = {quo_r, div_ok};

  // pixel position of the found cell
  logic [IW+RW-1:0] quo_ext;
  logic [RW-1:0]    row_q, row_off;
  logic [CW+7:0]    px_prod;
  logic [RW+7:0]    py_prod;
  logic [CW+23:0]   px_sum;
  logic [RW+23:0]   py_sum;

  assign quo_ext = {{RW{1'b0}}, quo_r};
  assign row_q   = quo_ext[RW-1:0];
  assign row_off = rows_eff - row_q - 1'b1;
  assign px_prod = rem_r * char_width_r;
  assign py_prod = line_height_r * row_off;
  assign px_sum  = {{(CW+8){1'b0}}, origin_x_r} + {16'b0, px_prod};
  assign py_sum  = {{(RW+8){1'b0}}, origin_y_r} + {16'b0, py_prod};

  // sequencer and next-state logic
  always_comb begin
    state_nxt       = state_r;
    cols_in_use_nxt = cols_in_use_r;
    rows_in_use_nxt = rows_in_use_r;
    char_width_nxt  = char_width_r;
    line_height_nxt = line_height_r;
    origin_x_nxt    = origin_x_r;
    origin_y_nxt    = origin_y_r;
    cursor_nxt      = cursor_r;
    sweep_nxt       = sweep_r;
    lim_m1_nxt      = lim_m1_r;
    put_col_nxt     = put_col_r;
    put_wrap_nxt    = put_wrap_r;
    ch_nxt          = ch_r;
    d_nxt           = d_r;
    wb_vld_nxt      = 1'b0;
    wb_addr_nxt     = wb_addr_r;
    wb_use_src_nxt  = wb_use_src_r;
    wb_const_nxt    = wb_const_r;
    prev_vld_nxt    = wb_vld_r;
    prev_idx_nxt    = wb_word_idx;
    prev_word_nxt   = wb_word;
    scan_w_nxt      = scan_w_r;
    scan_iss_nxt    = scan_iss_r;
    scan_v_nxt      = scan_v_r;
    eval_w_nxt      = eval_w_r;
    first_found_nxt = first_found_r;
    first_idx_nxt   = first_idx_r;
    first_word_nxt  = first_word_r;
    more_nxt        = more_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    div_cnt_nxt     = div_cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_found_nxt   = out_found_r;
    out_pix_x_nxt   = out_pix_x_r;
    out_pix_y_nxt   = out_pix_y_r;
    out_glyph_nxt   = out_glyph_r;
    out_more_nxt    = out_more_r;

    rd_src_addr = '0;
    rd_dst_addr = first_idx_r;
    dirty_raddr = scan_w_r;
    cell_we     = wb_vld_r;
    cell_waddr  = wb_addr_r;
    cell_wdata  = wb_val;
    dirty_we    = wb_vld_r;
    dirty_waddr = wb_word_idx;
    dirty_wdata = wb_word;

    // configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        REG_COLS:   cols_in_use_nxt = cfg_data[6:0];
        REG_ROWS:   rows_in_use_nxt = cfg_data[5:0];
        REG_CHAR_W: char_width_nxt  = cfg_data[7:0];
        REG_LINE_H: line_height_nxt = cfg_data[7:0];
        REG_ORG_X:  origin_x_nxt    = cfg_data;
        REG_ORG_Y:  origin_y_nxt    = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      // blank every cell and clear every dirty word
      ST_CLEAR: begin
        cell_we     = 1'b1;
        cell_waddr  = sweep_r;
        cell_wdata  = SPACE_CODE;
        dirty_we    = 1'b1;
        dirty_waddr = word_of(sweep_r);
        dirty_wdata = '0;
        if (sweep_r == IW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      // take an item
      ST_IDLE: begin
        if (in_valid) begin
          lim_m1_nxt = lim_m1_c;
          case (in_cmd)
            CMD_WRITE: begin
              if (in_ch == LINE_FEED) begin
                d_nxt     = lim_m1_c;
                state_nxt = ST_SCROLL;
              end else if (in_ch >= SPACE_CODE) begin
                put_col_nxt  = col_sel;
                put_wrap_nxt = col_wrap;
                ch_nxt       = in_ch;
                state_nxt    = ST_PUT;
              end
            end
            CMD_FETCH: begin
              scan_w_nxt      = '0;
              scan_iss_nxt    = 1'b1;
              scan_v_nxt      = 1'b0;
              first_found_nxt = 1'b0;
              more_nxt        = 1'b0;
              state_nxt       = ST_FSCAN;
            end
            CMD_CLEAR: begin
              sweep_nxt  = '0;
              cursor_nxt = '0;
              state_nxt  = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end

      // read the cursor cell for a printable character
      ST_PUT: begin
        rd_dst_addr    = put_addr;
        dirty_raddr    = word_of(put_addr);
        wb_vld_nxt     = 1'b1;
        wb_addr_nxt    = put_addr;
        wb_use_src_nxt = 1'b0;
        wb_const_nxt   = ch_r;
        state_nxt      = ST_PUTW;
      end

      // character written back; advance or scroll
      ST_PUTW: begin
        if (put_wrap_r) begin
          d_nxt     = lim_m1_r;
          state_nxt = ST_SCROLL;
        end else begin
          cursor_nxt = cur_inc[6:0];
          state_nxt  = ST_IDLE;
        end
      end

      // top cell down: each cell takes the one a row below, bottom row blanks
      ST_SCROLL: begin
        rd_dst_addr    = d_r;
        rd_src_addr    = src_full[IW-1:0];
        dirty_raddr    = word_of(d_r);
        wb_vld_nxt     = 1'b1;
        wb_addr_nxt    = d_r;
        wb_use_src_nxt = d_ge_cols;
        wb_const_nxt   = SPACE_CODE;
        if (d_r == '0) begin
          cursor_nxt = '0;
          state_nxt  = ST_IDLE;
        end else begin
          d_nxt = d_r - 1'b1;
        end
      end

      // walk dirty words, one read issued and one evaluated per cycle
      ST_FSCAN: begin
        if (scan_iss_r) begin
          dirty_raddr = scan_w_r;
          scan_v_nxt  = 1'b1;
          eval_w_nxt  = scan_w_r;
          if (scan_w_r == last_w) begin
            scan_iss_nxt = 1'b0;
          end else begin
            scan_w_nxt = scan_w_r + 1'b1;
          end
        end else begin
          scan_v_nxt = 1'b0;
        end
        if (scan_v_r) begin
          if (!first_found_r) begin
            if (masked_any) begin
              first_found_nxt = 1'b1;
              first_idx_nxt   = hit_idx;
              first_word_nxt  = dirty_rd_r;
              more_nxt        = masked_multi;
            end
          end else if (masked_any) begin
            more_nxt = 1'b1;
          end
          if ((eval_w_r == last_w) || more_nxt) begin
            if (first_found_r || masked_any) begin
              quo_nxt     = first_found_r ? first_idx_r : hit_idx;
              rem_nxt     = '0;
              div_cnt_nxt = DCW'(IW);
              state_nxt   = ST_FDIV;
            end else begin
              state_nxt = ST_FOUT;
            end
          end
        end
      end

      // clear the found dirty bit and split the address into row and column
      ST_FDIV: begin
        dirty_we    = 1'b1;
        dirty_waddr = word_of(first_idx_r);
        dirty_wdata = first_word_r & ~(32'd1 << bit_of(first_idx_r));
        rem_nxt     = div_ok ? div_diff[CW-1:0] : div_tmp[CW-1:0];
        quo_nxt     = quo_sh[IW-1:0];
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DCW'(1)) begin
          state_nxt = ST_FOUT;
        end
      end

      // load the result item once the output register is free
      ST_FOUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = first_found_r;
          if (first_found_r) begin
            out_pix_x_nxt = px_sum[15:0];
            out_pix_y_nxt = py_sum[15:0];
            out_glyph_nxt = cell_rdb_r;
            out_more_nxt  = more_r;
          end else begin
            out_pix_x_nxt = '0;
            out_pix_y_nxt = '0;
            out_glyph_nxt = '0;
            out_more_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      sweep_r       <= '0;
      cols_in_use_r <= 7'd64;
      rows_in_use_r <= 6'd32;
      char_width_r  <= 8'd8;
      line_height_r <= 8'd16;
      origin_x_r    <= 16'd0;
      origin_y_r    <= 16'd0;
      cursor_r      <= '0;
      wb_vld_r      <= 1'b0;
      prev_vld_r    <= 1'b0;
      scan_iss_r    <= 1'b0;
      scan_v_r      <= 1'b0;
      first_found_r <= 1'b0;
      more_r        <= 1'b0;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_r       <= sweep_nxt;
      cols_in_use_r <= cols_in_use_nxt;
      rows_in_use_r <= rows_in_use_nxt;
      char_width_r  <= char_width_nxt;
      line_height_r <= line_height_nxt;
      origin_x_r    <= origin_x_nxt;
      origin_y_r    <= origin_y_nxt;
      cursor_r      <= cursor_nxt;
      wb_vld_r      <= wb_vld_nxt;
      prev_vld_r    <= prev_vld_nxt;
      scan_iss_r    <= scan_iss_nxt;
      scan_v_r      <= scan_v_nxt;
      first_found_r <= first_found_nxt;
      more_r        <= more_nxt;
      div_cnt_r     <= div_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lim_m1_r     <= lim_m1_nxt;
    put_col_r    <= put_col_nxt;
    put_wrap_r   <= put_wrap_nxt;
    ch_r         <= ch_nxt;
    d_r          <= d_nxt;
    wb_addr_r    <= wb_addr_nxt;
    wb_use_src_r <= wb_use_src_nxt;
    wb_const_r   <= wb_const_nxt;
    prev_idx_r   <= prev_idx_nxt;
    prev_word_r  <= prev_word_nxt;
    scan_w_r     <= scan_w_nxt;
    eval_w_r     <= eval_w_nxt;
    first_idx_r  <= first_idx_nxt;
    first_word_r <= first_word_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    out_found_r  <= out_found_nxt;
    out_pix_x_r  <= out_pix_x_nxt;
    out_pix_y_r  <= out_pix_y_nxt;
    out_glyph_r  <= out_glyph_nxt;
    out_more_r   <= out_more_nxt;
  end

  // cell store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rda_r <= cell_mem[rd_src_addr];
    cell_rdb_r <= cell_mem[rd_dst_addr];
  end

  // dirty map: 32 cells per word, one write port, one registered read port
  always_ff @(posedge clk) begin
    if (dirty_we) begin
      dirty_mem[dirty_waddr] <= dirty_wdata;
    end
    dirty_rd_r <= dirty_mem[dirty_raddr];
  end

  // ports
  assign in_ready       = state_r == ST_IDLE;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_pix_x      = out_pix_x_r;
  assign out_pix_y      = out_pix_y_r;
  assign out_glyph_code = out_glyph_r;
  assign out_more       = out_more_r;

  // checks
  `STCDM_ASSERT_IMPLY(a_nofind_zero, out_valid && !out_found, (out_pix_x == 16'd0) && (out_pix_y == 16'd0) && (out_glyph_code == 8'd0) && !out_more, "empty fetch item carries nonzero fields")
  `STCDM_ASSERT_IMPLY(a_more_needs_found, out_valid && out_more, out_found, "more flagged without a found cell")
  `STCDM_ASSERT_IMPLY(a_scan_in_range, (state_r == ST_FSCAN) && scan_v_r, eval_w_r <= last_w, "dirty scan evaluated a word past the console area")
  `STCDM_ASSERT_IMPLY(a_clear_no_wb, state_r == ST_CLEAR, !wb_vld_r, "cell write-back collides with the clearing sweep")
  `STCDM_ASSERT_NEXT(a_put_writes_back, state_r == ST_PUT, wb_vld_r && (state_r == ST_PUTW), "character read not followed by its write-back")

endmodule

`default_nettype wire
